/* rtl/core/bfrm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brace fold package
// Shared constants, character codes and command types of the fold matcher.
// ----------------------------------------------------------------------------
package bfrm_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
	localparam int LINE_BITS   = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	localparam logic ACT_START = 1'b0;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH,
		OP_POP,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [LINE_BITS-1:0] line;
	} cmd_t;

endpackage

/* rtl/core/bfrm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module bfrm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/bfrm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fold matcher front end
// Accepts characters, tracks quote and escape state, classifies stack ops.
// ----------------------------------------------------------------------------
module bfrm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // line_number[15:0], ch[23:16]
	input  logic [1:0]           s_tuser,   // action[0], line_start[1]
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output bfrm_pkg::cmd_t       cmd
);

	logic       sq_q, dq_q, esc_q;
	logic       sq_c, dq_c, esc_c;
	logic       action, lstart, accept;
	logic [7:0] ch;

	assign action    = s_tuser[0];
	assign lstart    = s_tuser[1];
	assign ch        = s_tdata[23:16];
	assign s_tready  = cmd_ready;
	assign cmd_valid = s_tvalid;
	assign accept    = s_tvalid && cmd_ready;

	assign sq_c  = lstart ? 1'b0 : sq_q;
	assign dq_c  = lstart ? 1'b0 : dq_q;
	assign esc_c = lstart ? 1'b0 : esc_q;

	always_comb begin
		cmd.line = s_tdata[15:0];
		cmd.op   = bfrm_pkg::OP_NONE;
		if (action == bfrm_pkg::ACT_START) begin
			cmd.op = bfrm_pkg::OP_CLEAR;
		end else if (!(sq_c || dq_c)) begin
			if (ch == bfrm_pkg::CH_LBRACE) begin
				cmd.op = bfrm_pkg::OP_PUSH;
			end else if (ch == bfrm_pkg::CH_RBRACE) begin
				cmd.op = bfrm_pkg::OP_POP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q  <= 1'b0;
			dq_q  <= 1'b0;
			esc_q <= 1'b0;
		end else if (accept) begin
			if (action == bfrm_pkg::ACT_START) begin
				sq_q  <= 1'b0;
				dq_q  <= 1'b0;
				esc_q <= 1'b0;
			end else begin
				sq_q  <= sq_c;
				dq_q  <= dq_c;
				esc_q <= esc_c;
				if (esc_c) begin
					esc_q <= 1'b0;
				end else if (ch == bfrm_pkg::CH_BSLASH) begin
					esc_q <= 1'b1;
				end else if (ch == bfrm_pkg::CH_SQUOTE && !dq_c) begin
					sq_q <= !sq_c;
				end else if (ch == bfrm_pkg::CH_DQUOTE && !sq_c) begin
					dq_q <= !dq_c;
				end
			end
		end
	end

endmodule

/* rtl/core/bfrm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO between the front end and the stack engine.
// ----------------------------------------------------------------------------
module bfrm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bfrm_pkg::cmd_t in_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output bfrm_pkg::cmd_t out_cmd
);

	bfrm_pkg::cmd_t                  mem_q [bfrm_pkg::QUEUE_DEPTH];
	logic [bfrm_pkg::QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [bfrm_pkg::QCOUNT_W-1:0]   count_q;
	logic                            push, pop;

	assign in_ready  = count_q != bfrm_pkg::QCOUNT_W'(bfrm_pkg::QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bfrm_pkg::QCOUNT_W'(bfrm_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on request");

endmodule

/* rtl/core/bfrm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack engine
// Executes push, pop and clear on the open-line stack and forms fold results.
// ----------------------------------------------------------------------------
module bfrm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_ready,
	input  bfrm_pkg::cmd_t                    cmd,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              fold_valid,
	output logic [bfrm_pkg::LINE_BITS-1:0]    fold_first_line,
	output logic [bfrm_pkg::LINE_BITS-1:0]    fold_last_line,
	output logic                              push_dropped
);

	localparam int AW = bfrm_pkg::STACK_AW;
	localparam int FW = bfrm_pkg::FILL_W;
	localparam int LW = bfrm_pkg::LINE_BITS;

	logic [FW-1:0] fill_q, fill_d, fill_m1;
	logic          issue, adv, we, re, hit, drop;
	logic [LW-1:0] rdata;

	logic          valid_s1, hit_s1, drop_s1;
	logic [LW-1:0] line_s1;

	logic          out_valid_q, out_fold_q, out_drop_q;
	logic [LW-1:0] out_first_q, out_last_q;
	logic          fold_c;

	assign adv       = !out_valid_q || out_ready;
	assign cmd_ready = !valid_s1 || adv;
	assign issue     = cmd_valid && cmd_ready;
	assign fill_m1   = fill_q - 1'b1;

	always_comb begin
		fill_d = fill_q;
		we     = 1'b0;
		re     = 1'b0;
		hit    = 1'b0;
		drop   = 1'b0;
		if (issue) begin
			unique case (cmd.op)
				bfrm_pkg::OP_CLEAR: begin
					fill_d = '0;
				end
				bfrm_pkg::OP_PUSH: begin
					if (fill_q < FW'(bfrm_pkg::STACK_DEPTH)) begin
						we     = 1'b1;
						fill_d = fill_q + 1'b1;
					end else begin
						drop = 1'b1;
					end
				end
				bfrm_pkg::OP_POP: begin
					if (fill_q != '0) begin
						re     = 1'b1;
						hit    = 1'b1;
						fill_d = fill_m1;
					end
				end
				default: begin
					fill_d = fill_q;
				end
			endcase
		end
	end

	bfrm_ram #(
		.WIDTH (LW),
		.DEPTH (bfrm_pkg::STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (fill_q[AW-1:0]),
		.wdata (cmd.line),
		.re    (re),
		.raddr (fill_m1[AW-1:0]),
		.rdata (rdata)
	);

	assign fold_c = hit_s1 && (rdata < line_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (cmd_ready) begin
				valid_s1 <= issue;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			hit_s1  <= hit;
			drop_s1 <= drop;
			line_s1 <= cmd.line;
		end
		if (adv && valid_s1) begin
			out_fold_q  <= fold_c;
			out_drop_q  <= drop_s1;
			out_first_q <= fold_c ? rdata : '0;
			out_last_q  <= fold_c ? line_s1 : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign fold_valid      = out_fold_q;
	assign push_dropped    = out_drop_q;
	assign fold_first_line = out_first_q;
	assign fold_last_line  = out_last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(bfrm_pkg::STACK_DEPTH))
		else $error("stack fill beyond depth");

	a_fold_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_fold_q |-> out_first_q < out_last_q)
		else $error("fold region not ordered");

	a_fold_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_fold_q && out_drop_q))
		else $error("fold and dropped push on one result");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		issue && drop |-> fill_q == FW'(bfrm_pkg::STACK_DEPTH))
		else $error("push dropped below full stack");

endmodule

/* rtl/core/brace_fold_region_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brace fold region matcher
// Matches braces outside quotes on a character stream and reports folds.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                   | tuser
//  s_*      | in  | [15:0] line_number, [23:16] ch          | [0] action, [1] line_start
//  m_*      | out | [15:0] fold_first_line, [31:16] last    | [0] fold_valid, [1] push_dropped
//
//  One request per cycle unless the output stalls; one result per request, in order.
//  Requests pass the command queue, the stack issue stage and the result register.
//  The stack RAM read (one read port, registered) sets the issue-to-result stage.
//  Reset clears quote state, queue and stack fill; stack contents stay undefined.
//  A stalled output holds its result; the queue absorbs up to four requests.
// ----------------------------------------------------------------------------
module brace_fold_region_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // line_number[15:0], ch[23:16]
	input  logic [1:0]  s_tuser,   // action[0], line_start[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // fold_first_line[15:0], fold_last_line[31:16]
	output logic [1:0]  m_tuser    // fold_valid[0], push_dropped[1]
);

	logic           f_valid, f_ready, q_valid, q_ready;
	bfrm_pkg::cmd_t f_cmd, q_cmd;
	logic           fold_valid, push_dropped;
	logic [15:0]    first_line, last_line;

	bfrm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	bfrm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_cmd    (f_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	bfrm_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (q_valid),
		.cmd_ready       (q_ready),
		.cmd             (q_cmd),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.fold_valid      (fold_valid),
		.fold_first_line (first_line),
		.fold_last_line  (last_line),
		.push_dropped    (push_dropped)
	);

	assign m_tdata = {last_line, first_line};
	assign m_tuser = {push_dropped, fold_valid};

endmodule
